[design/cwe_pkg.sv]
package cwe_pkg;

   localparam int NUM_ENTRIES = 16;
   localparam int WORD_BYTES  = 4;

   // Only the low WORD_BYTES bytes of a word take part in the match, at most 32 bits.
   localparam int WORD_W      = (WORD_BYTES * 8 > 32) ? 32 : WORD_BYTES * 8;
   localparam int DATA_W      = 32;
   localparam int ENTRY_W     = $clog2(NUM_ENTRIES);
   localparam int COUNT_W     = 4;
   localparam int RSP_INDEX_W = 4;
   localparam int CSR_DATA_W  = 4;
   localparam int CSR_INDEX_W = 1;

   localparam logic [COUNT_W-1:0] COUNT_MAX     = {COUNT_W{1'b1}};
   localparam logic [COUNT_W-1:0] COUNT_ONE     = COUNT_W'(1);
   localparam logic [ENTRY_W-1:0] RANK_LAST     = ENTRY_W'(NUM_ENTRIES - 1);
   localparam logic [CSR_DATA_W-1:0] SAT_RESET  = CSR_DATA_W'(15);

   localparam logic MODE_LRU = 1'b0;
   localparam logic MODE_LFU = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_REPLACE_MODE   = 1'b0,
      CSR_LFU_SATURATION = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_TOUCH,
      OP_FILL_LRU,
      OP_FILL_LFU,
      OP_INC,
      OP_HALVE
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MATCH,
      ST_LRU_TOUCH,
      ST_LRU_FIND,
      ST_LRU_FILL,
      ST_LFU_INC,
      ST_LFU_CHECK,
      ST_LFU_SCAN,
      ST_LFU_FILL,
      ST_RESULT
   } state_type;

   typedef struct packed {
      op_type              op;
      logic [ENTRY_W-1:0]  entry;
      logic [WORD_W-1:0]   word;
      logic [ENTRY_W-1:0]  rank_query;
   } cmd_type;

   typedef struct packed {
      logic                hit;
      logic [ENTRY_W-1:0]  hit_entry;
      logic [ENTRY_W-1:0]  rank_entry;
      logic                rank_valid;
      logic [COUNT_W-1:0]  rank_count;
      logic [COUNT_W-1:0]  sel_count;
   } status_type;

endpackage

[design/cwe_store.sv]
module cwe_store (
   input  logic                 clock,
   input  logic                 reset,
   input  cwe_pkg::cmd_type     cmd,
   output cwe_pkg::status_type  status
);

   logic [cwe_pkg::WORD_W-1:0]  word_ff  [cwe_pkg::NUM_ENTRIES];
   logic [cwe_pkg::NUM_ENTRIES-1:0] valid_ff, valid_in;
   logic [cwe_pkg::ENTRY_W-1:0] rank_ff  [cwe_pkg::NUM_ENTRIES];
   logic [cwe_pkg::ENTRY_W-1:0] rank_in  [cwe_pkg::NUM_ENTRIES];
   logic [cwe_pkg::COUNT_W-1:0] count_ff [cwe_pkg::NUM_ENTRIES];
   logic [cwe_pkg::COUNT_W-1:0] count_in [cwe_pkg::NUM_ENTRIES];
   logic [cwe_pkg::ENTRY_W-1:0] old_rank;
   logic                        is_fill;
   logic                        is_touch;

   always_comb begin
      // Parallel tag match, lowest matching entry wins.
      status.hit       = 1'b0;
      status.hit_entry = '0;
      for (int i = cwe_pkg::NUM_ENTRIES - 1; i >= 0; i--) begin
         if (valid_ff[i] && (word_ff[i] == cmd.word)) begin
            status.hit       = 1'b1;
            status.hit_entry = cwe_pkg::ENTRY_W'(i);
         end
      end
      // Ranks always form a permutation, so exactly one entry answers a rank query.
      status.rank_entry = '0;
      for (int i = 0; i < cwe_pkg::NUM_ENTRIES; i++) begin
         if (rank_ff[i] == cmd.rank_query) begin
            status.rank_entry = cwe_pkg::ENTRY_W'(i);
         end
      end
      status.rank_valid = valid_ff[status.rank_entry];
      status.rank_count = count_ff[status.rank_entry];
      status.sel_count  = count_ff[cmd.entry];
   end

   always_comb begin
      is_fill  = (cmd.op == cwe_pkg::OP_FILL_LRU) || (cmd.op == cwe_pkg::OP_FILL_LFU);
      is_touch = (cmd.op == cwe_pkg::OP_TOUCH) || (cmd.op == cwe_pkg::OP_FILL_LRU);
      old_rank = rank_ff[cmd.entry];
      valid_in = valid_ff;
      if (is_fill) begin
         valid_in[cmd.entry] = 1'b1;
      end
      for (int i = 0; i < cwe_pkg::NUM_ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
         if (is_touch) begin
            if (cwe_pkg::ENTRY_W'(i) == cmd.entry) begin
               rank_in[i] = '0;
            end else if (rank_ff[i] < old_rank) begin
               rank_in[i] = rank_ff[i] + cwe_pkg::ENTRY_W'(1);
            end
         end
         count_in[i] = count_ff[i];
         case (cmd.op)
            cwe_pkg::OP_INC: begin
               if ((cwe_pkg::ENTRY_W'(i) == cmd.entry) && (count_ff[i] != cwe_pkg::COUNT_MAX)) begin
                  count_in[i] = count_ff[i] + cwe_pkg::COUNT_ONE;
               end
            end
            cwe_pkg::OP_HALVE: begin
               count_in[i] = count_ff[i] >> 1;
            end
            cwe_pkg::OP_FILL_LFU: begin
               if (cwe_pkg::ENTRY_W'(i) == cmd.entry) begin
                  count_in[i] = cwe_pkg::COUNT_ONE;
               end
            end
            default: begin
               count_in[i] = count_ff[i];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         for (int i = 0; i < cwe_pkg::NUM_ENTRIES; i++) begin
            rank_ff[i]  <= cwe_pkg::ENTRY_W'(i);
            count_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         for (int i = 0; i < cwe_pkg::NUM_ENTRIES; i++) begin
            rank_ff[i]  <= rank_in[i];
            count_ff[i] <= count_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (is_fill) begin
         word_ff[cmd.entry] <= cmd.word;
      end
   end

endmodule

[design/cwe_seq.sv]
module cwe_seq (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [cwe_pkg::DATA_W-1:0]        req_data_word,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_hit,
   output logic [cwe_pkg::RSP_INDEX_W-1:0]   rsp_index,
   input  logic                              replace_mode,
   input  logic [cwe_pkg::COUNT_W-1:0]       lfu_saturation,
   output cwe_pkg::cmd_type                  cmd,
   input  cwe_pkg::status_type               status
);

   cwe_pkg::state_type              state_ff, state_in;
   logic [cwe_pkg::WORD_W-1:0]      word_ff;
   logic                            hit_ff;
   logic [cwe_pkg::ENTRY_W-1:0]     found_ff;
   logic [cwe_pkg::ENTRY_W-1:0]     victim_ff, victim_in;
   logic [cwe_pkg::COUNT_W-1:0]     least_ff, least_in;
   logic [cwe_pkg::ENTRY_W-1:0]     scan_rank_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_hit_ff;
   logic [cwe_pkg::RSP_INDEX_W-1:0] rsp_index_ff;
   logic                            rsp_load;
   logic                            take_victim;
   logic                            scan_done;

   // An invalid entry ends the scan at once; otherwise the smallest count wins,
   // first in recency order.
   always_comb begin
      take_victim = (scan_rank_ff == '0) || !status.rank_valid ||
                    (status.rank_count < least_ff);
      scan_done   = !status.rank_valid || (scan_rank_ff == cwe_pkg::RANK_LAST);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cwe_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = cwe_pkg::ST_MATCH;
            end
         end
         cwe_pkg::ST_MATCH: begin
            if (replace_mode == cwe_pkg::MODE_LRU) begin
               state_in = status.hit ? cwe_pkg::ST_LRU_TOUCH : cwe_pkg::ST_LRU_FIND;
            end else begin
               state_in = status.hit ? cwe_pkg::ST_LFU_INC : cwe_pkg::ST_LFU_SCAN;
            end
         end
         cwe_pkg::ST_LRU_TOUCH: state_in = cwe_pkg::ST_RESULT;
         cwe_pkg::ST_LRU_FIND:  state_in = cwe_pkg::ST_LRU_FILL;
         cwe_pkg::ST_LRU_FILL:  state_in = cwe_pkg::ST_RESULT;
         cwe_pkg::ST_LFU_INC:   state_in = cwe_pkg::ST_LFU_CHECK;
         cwe_pkg::ST_LFU_CHECK: state_in = cwe_pkg::ST_RESULT;
         cwe_pkg::ST_LFU_SCAN: begin
            if (scan_done) begin
               state_in = cwe_pkg::ST_LFU_FILL;
            end
         end
         cwe_pkg::ST_LFU_FILL:  state_in = cwe_pkg::ST_RESULT;
         cwe_pkg::ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = cwe_pkg::ST_IDLE;
            end
         end
         default: state_in = cwe_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready      = 1'b0;
      rsp_load       = 1'b0;
      cmd.op         = cwe_pkg::OP_NONE;
      cmd.entry      = found_ff;
      cmd.word       = word_ff;
      cmd.rank_query = scan_rank_ff;
      case (state_ff)
         cwe_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         cwe_pkg::ST_LRU_TOUCH: begin
            cmd.op = cwe_pkg::OP_TOUCH;
         end
         cwe_pkg::ST_LRU_FIND: begin
            cmd.rank_query = cwe_pkg::RANK_LAST;
         end
         cwe_pkg::ST_LRU_FILL: begin
            cmd.op    = cwe_pkg::OP_FILL_LRU;
            cmd.entry = victim_ff;
         end
         cwe_pkg::ST_LFU_INC: begin
            cmd.op = cwe_pkg::OP_INC;
         end
         cwe_pkg::ST_LFU_CHECK: begin
            if (status.sel_count >= lfu_saturation) begin
               cmd.op = cwe_pkg::OP_HALVE;
            end
         end
         cwe_pkg::ST_LFU_FILL: begin
            cmd.op    = cwe_pkg::OP_FILL_LFU;
            cmd.entry = victim_ff;
         end
         cwe_pkg::ST_RESULT: begin
            rsp_load = !rsp_valid_ff || rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      victim_in = victim_ff;
      least_in  = least_ff;
      if (state_ff == cwe_pkg::ST_LRU_FIND) begin
         victim_in = status.rank_entry;
      end else if ((state_ff == cwe_pkg::ST_LFU_SCAN) && take_victim) begin
         victim_in = status.rank_entry;
         least_in  = status.rank_count;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cwe_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      victim_ff <= victim_in;
      least_ff  <= least_in;
      if ((state_ff == cwe_pkg::ST_IDLE) && req_valid) begin
         word_ff <= req_data_word[cwe_pkg::WORD_W-1:0];
      end
      if (state_ff == cwe_pkg::ST_MATCH) begin
         hit_ff       <= status.hit;
         found_ff     <= status.hit_entry;
         scan_rank_ff <= '0;
      end else if (state_ff == cwe_pkg::ST_LFU_SCAN) begin
         scan_rank_ff <= scan_rank_ff + cwe_pkg::ENTRY_W'(1);
      end
      if (rsp_load) begin
         rsp_hit_ff   <= hit_ff;
         rsp_index_ff <= hit_ff ? cwe_pkg::RSP_INDEX_W'(found_ff) : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = rsp_hit_ff;
   assign rsp_index = rsp_index_ff;

endmodule

[design/cam_word_encoder_lru_lfu_unit.sv]
// Looks up each 32-bit word in a 16-entry content-addressable table and returns
// the matching index, or a miss after writing the word into a victim entry chosen
// by least-recently-used or least-frequently-used replacement (csr register 0),
// with use counts halved once a hit count reaches csr register 1. Items are taken
// one at a time by a small sequencer around a shared table unit whose one rank
// lookup port serves both replacement policies. An LFU miss walks the table
// entries in recency order until the first invalid entry or the end of the table.
// A finished result sits in an output register, and a stall on the result side
// only holds the sequencer once the next result is ready. Configuration must be
// written only while the block is idle; the block itself does not enforce this.
module cam_word_encoder_lru_lfu_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [cwe_pkg::DATA_W-1:0]        req_data_word,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_hit,
   output logic [cwe_pkg::RSP_INDEX_W-1:0]   rsp_index,
   input  logic                              csr_write_enable,
   input  logic [cwe_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [cwe_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   logic                          replace_mode_ff;
   logic [cwe_pkg::COUNT_W-1:0]   lfu_saturation_ff;
   cwe_pkg::cmd_type              cmd;
   cwe_pkg::status_type           status;

   always_ff @(posedge clock) begin
      if (reset) begin
         replace_mode_ff   <= cwe_pkg::MODE_LRU;
         lfu_saturation_ff <= cwe_pkg::SAT_RESET;
      end else if (csr_write_enable) begin
         case (cwe_pkg::csr_index_type'(csr_index))
            cwe_pkg::CSR_REPLACE_MODE: begin
               replace_mode_ff <= csr_write_data[0];
            end
            cwe_pkg::CSR_LFU_SATURATION: begin
               lfu_saturation_ff <= csr_write_data[cwe_pkg::COUNT_W-1:0];
            end
            default: begin
               replace_mode_ff <= replace_mode_ff;
            end
         endcase
      end
   end

   cwe_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_word  (req_data_word),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hit        (rsp_hit),
      .rsp_index      (rsp_index),
      .replace_mode   (replace_mode_ff),
      .lfu_saturation (lfu_saturation_ff),
      .cmd            (cmd),
      .status         (status)
   );

   cwe_store u_store (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .status (status)
   );

endmodule
